/* rtl/core/kocnt_pkg.sv */
// ----------------------------------------------------------------------------
// Key occurrence count table package
// Shared request/response types, operation and status codes, and the
// per-slot layout of one bucket row in the table memory.
// ----------------------------------------------------------------------------
`default_nettype none

package kocnt_pkg;

   // Default geometry
   localparam int BUCKETS_DEFAULT = 256;
   localparam int WAYS_DEFAULT    = 4;

   // Field widths
   localparam int KIND_W   = 2;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 32;
   localparam int USED_W   = 11;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

   // Saturation limits
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [USED_W-1:0]  USED_MAX  = '1;

   // Request payload
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;
   } req_type;

   // Response payload
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic [USED_W-1:0]   entries_used;
   } rsp_type;

   // One way of a bucket row
   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [COUNT_W-1:0] count;
   } slot_type;

endpackage

`default_nettype wire

/* rtl/core/kocnt_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module kocnt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/kocnt_bucket.sv */
// ----------------------------------------------------------------------------
// Bucket index pipeline
// Input register plus two multiply stages that reduce the key modulo the
// bucket count by reciprocal multiplication and one correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module kocnt_bucket #(
   parameter int BUCKETS = kocnt_pkg::BUCKETS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic                       in_valid,
   input  wire kocnt_pkg::req_type         in_req,
   output logic                            out_valid,
   output kocnt_pkg::req_type              out_req,
   output logic [$clog2(BUCKETS)-1:0]      out_bucket
);

   localparam int BUCKET_W = $clog2(BUCKETS);
   localparam int REM_W    = BUCKET_W + 1;
   // floor(2^32 / BUCKETS): quotient estimate is low by at most one
   localparam logic [63:0] RECIP_FULL = (64'd1 << 32) / 64'(BUCKETS);
   localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
   localparam logic [31:0] DIVISOR    = 32'(BUCKETS);
   localparam logic [REM_W-1:0] DIVISOR_REM = REM_W'(BUCKETS);

   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff;
   kocnt_pkg::req_type  s1_req_ff, s2_req_ff, s3_req_ff;
   logic [31:0]         quot_ff;
   logic [31:0]         prod_ff;
   logic [63:0]         recip_mul;
   logic [31:0]         quot_in;
   logic [31:0]         prod_in;
   logic [31:0]         diff;
   logic [REM_W-1:0]    rem_raw;
   logic [REM_W-1:0]    rem_fix;

   // Stage 2: quotient estimate
   always_comb begin
      recip_mul = {32'd0, s1_req_ff.key} * {32'd0, RECIP};
      quot_in   = recip_mul[63:32];
   end

   // Stage 3: quotient times divisor, low word only
   assign prod_in = quot_ff * DIVISOR;

   // Remainder with a single correction
   always_comb begin
      diff    = s3_req_ff.key - prod_ff;
      rem_raw = diff[REM_W-1:0];
      if (rem_raw >= DIVISOR_REM) begin
         rem_fix = rem_raw - DIVISOR_REM;
      end else begin
         rem_fix = rem_raw;
      end
   end

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Payload chain
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_req_ff <= in_req;
         s2_req_ff <= s1_req_ff;
         s3_req_ff <= s2_req_ff;
         quot_ff   <= quot_in;
         prod_ff   <= prod_in;
      end
   end

   assign out_valid  = s3_valid_ff;
   assign out_req    = s3_req_ff;
   assign out_bucket = rem_fix[BUCKET_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/kocnt_update.sv */
// ----------------------------------------------------------------------------
// Bucket row update
// Compares all ways of one bucket row in parallel, applies insert, pop or
// lookup, and forms the new row, the occupancy and the response.
// ----------------------------------------------------------------------------
`default_nettype none

module kocnt_update #(
   parameter int BUCKETS = kocnt_pkg::BUCKETS_DEFAULT,
   parameter int WAYS    = kocnt_pkg::WAYS_DEFAULT
) (
   input  wire kocnt_pkg::req_type                        req,
   input  wire kocnt_pkg::slot_type [WAYS-1:0]            row_in,
   input  wire logic [$clog2(BUCKETS*WAYS+1)-1:0]         occ_in,
   output logic                                           wr_en,
   output kocnt_pkg::slot_type [WAYS-1:0]                 row_out,
   output logic [$clog2(BUCKETS*WAYS+1)-1:0]              occ_out,
   output kocnt_pkg::rsp_type                             rsp
);

   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int OCC_W = $clog2(BUCKETS*WAYS+1);
   localparam int EXT_W = (OCC_W > kocnt_pkg::USED_W) ? OCC_W : kocnt_pkg::USED_W;

   logic                              hit_found;
   logic [WAY_W-1:0]                  hit_idx;
   logic                              free_found;
   logic [WAY_W-1:0]                  free_idx;
   logic [kocnt_pkg::COUNT_W-1:0]     cur_count;
   logic [kocnt_pkg::COUNT_W-1:0]     inc_count;
   logic [EXT_W-1:0]                  occ_ext;

   // Parallel way compare, lowest way wins
   always_comb begin
      hit_found  = 1'b0;
      hit_idx    = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (row_in[w].valid) begin
            if (!hit_found && (row_in[w].key == req.key)) begin
               hit_found = 1'b1;
               hit_idx   = WAY_W'(w);
            end
         end else if (!free_found) begin
            free_found = 1'b1;
            free_idx   = WAY_W'(w);
         end
      end
   end

   // Saturating increment of the matching count
   always_comb begin
      cur_count = row_in[hit_idx].count;
      if (cur_count != kocnt_pkg::COUNT_MAX) begin
         inc_count = cur_count + 1'b1;
      end else begin
         inc_count = cur_count;
      end
   end

   // Operation
   always_comb begin
      wr_en      = 1'b0;
      row_out    = row_in;
      occ_out    = occ_in;
      rsp.status = kocnt_pkg::STATUS_ABSENT;
      rsp.count  = '0;
      case (req.kind)
         kocnt_pkg::KIND_INSERT: begin
            if (hit_found) begin
               wr_en                  = 1'b1;
               row_out[hit_idx].count = inc_count;
               rsp.status             = kocnt_pkg::STATUS_OK;
               rsp.count              = inc_count;
            end else if (free_found) begin
               wr_en                   = 1'b1;
               row_out[free_idx].valid = 1'b1;
               row_out[free_idx].key   = req.key;
               row_out[free_idx].count = kocnt_pkg::COUNT_W'(1);
               occ_out                 = occ_in + 1'b1;
               rsp.status              = kocnt_pkg::STATUS_OK;
               rsp.count               = kocnt_pkg::COUNT_W'(1);
            end else begin
               rsp.status = kocnt_pkg::STATUS_FULL;
            end
         end
         kocnt_pkg::KIND_POP: begin
            if (hit_found) begin
               wr_en            = 1'b1;
               row_out[hit_idx] = '0;
               if (occ_in != '0) begin
                  occ_out = occ_in - 1'b1;
               end
               rsp.status = kocnt_pkg::STATUS_OK;
               rsp.count  = cur_count;
            end
         end
         default: begin
            // lookup, and the unused code behaves as lookup
            if (hit_found) begin
               rsp.status = kocnt_pkg::STATUS_OK;
               rsp.count  = cur_count;
            end
         end
      endcase

      // Occupancy field saturates at its maximum
      occ_ext = EXT_W'(occ_out);
      if (occ_ext > EXT_W'(kocnt_pkg::USED_MAX)) begin
         rsp.entries_used = kocnt_pkg::USED_MAX;
      end else begin
         rsp.entries_used = occ_ext[kocnt_pkg::USED_W-1:0];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/key_occurrence_count_table.sv */
// Throughput: one request per cycle while req_stall is low; one bucket row
// read-modify-write per item, with the written row forwarded to a back-to-back
// item on the same bucket.
// Reset: synchronous; afterwards a clearing pass writes all BUCKETS rows, one per
// cycle, and req_stall stays high until the pass ends.
// ----------------------------------------------------------------------------
// Key occurrence count table
// Set-associative key-to-count store: bucket = key mod BUCKETS, WAYS slots
// per bucket kept in one memory row, insert/increment, pop and lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module key_occurrence_count_table #(
   parameter int BUCKETS = kocnt_pkg::BUCKETS_DEFAULT,
   parameter int WAYS    = kocnt_pkg::WAYS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire kocnt_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output kocnt_pkg::rsp_type      rsp_data
);

   localparam int BUCKET_W = $clog2(BUCKETS);
   localparam int ROW_W    = WAYS * $bits(kocnt_pkg::slot_type);
   localparam int OCC_W    = $clog2(BUCKETS*WAYS+1);

   logic                           advance;
   logic                           req_accept;

   // bucket pipeline
   logic                           s3_valid;
   kocnt_pkg::req_type             s3_req;
   logic [BUCKET_W-1:0]            s3_bucket;

   // row stage
   logic                           s4_valid_ff;
   kocnt_pkg::req_type             s4_req_ff;
   logic [BUCKET_W-1:0]            s4_bucket_ff;

   // forwarding of the last written row
   logic                           fwd_ff;
   logic                           fwd_in;
   logic [ROW_W-1:0]               fwd_row_ff;

   // clearing pass
   logic                           clearing_ff;
   logic [BUCKET_W-1:0]            clr_cnt_ff;

   // memory
   logic                           ram_wr_en;
   logic [BUCKET_W-1:0]            ram_wr_addr;
   logic [ROW_W-1:0]               ram_wr_data;
   logic [ROW_W-1:0]               ram_rd_data;

   // update
   kocnt_pkg::slot_type [WAYS-1:0] row_cur;
   kocnt_pkg::slot_type [WAYS-1:0] row_new;
   logic                           upd_wr_en;
   logic [OCC_W-1:0]               occ_ff;
   logic [OCC_W-1:0]               occ_new;
   kocnt_pkg::rsp_type             upd_rsp;

   // output register
   logic                           rsp_valid_ff;
   kocnt_pkg::rsp_type             rsp_ff;

   // Whole pipeline moves when the output register can take a result
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = clearing_ff || !advance;
   assign req_accept = req_valid && !req_stall;

   kocnt_bucket #(
      .BUCKETS(BUCKETS)
   ) u_bucket (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_accept),
      .in_req    (req_data),
      .out_valid (s3_valid),
      .out_req   (s3_req),
      .out_bucket(s3_bucket)
   );

   // Clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == BUCKET_W'(BUCKETS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Memory write port: clearing pass or row write-back
   assign ram_wr_en   = clearing_ff || (advance && s4_valid_ff && upd_wr_en);
   assign ram_wr_addr = clearing_ff ? clr_cnt_ff : s4_bucket_ff;
   assign ram_wr_data = clearing_ff ? '0 : ROW_W'(row_new);

   kocnt_ram #(
      .WIDTH(ROW_W),
      .DEPTH(BUCKETS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (advance),
      .rd_addr(s3_bucket),
      .rd_data(ram_rd_data)
   );

   // Row stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_req_ff    <= s3_req;
         s4_bucket_ff <= s3_bucket;
      end
   end

   // Same bucket read while the previous item writes it: take the new row
   assign fwd_in = s3_valid && s4_valid_ff && upd_wr_en && (s3_bucket == s4_bucket_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (advance) begin
         fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fwd_row_ff <= ROW_W'(row_new);
      end
   end

   assign row_cur = fwd_ff ? fwd_row_ff : ram_rd_data;

   kocnt_update #(
      .BUCKETS(BUCKETS),
      .WAYS   (WAYS)
   ) u_update (
      .req    (s4_req_ff),
      .row_in (row_cur),
      .occ_in (occ_ff),
      .wr_en  (upd_wr_en),
      .row_out(row_new),
      .occ_out(occ_new),
      .rsp    (upd_rsp)
   );

   // Occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (advance && s4_valid_ff) begin
         occ_ff <= occ_new;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= upd_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
